/* hw/rtl/floor_direction_queue_bank_defines.svh */
// Assertion macros used by the queue bank datapath.
`ifndef FLOOR_DIRECTION_QUEUE_BANK_DEFINES_SVH
`define FLOOR_DIRECTION_QUEUE_BANK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDQB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDQB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/fdqb_pkg.sv */
// Types and constants shared by the queue bank controller, datapath and top level.
package fdqb_pkg;

	localparam int unsigned MODE_W    = 2;
	localparam int unsigned FLOOR_W   = 5;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned LEN_OUT_W = 5;
	localparam int unsigned ENTRY_W   = ID_W + FLOOR_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_ENQ = 2'd0,
		MODE_DEQ = 2'd1,
		MODE_DEL = 2'd2,
		MODE_CNT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_BAD,
		RES_OK_CUR,
		RES_ERR_CUR
	} res_op_t;

	typedef struct packed {
		logic    load;
		logic    len_rd;
		logic    enq;
		logic    scan_init;
		logic    scan_run;
		logic    finish;
		res_op_t res_op;
	} dp_cmd_t;

	typedef struct packed {
		logic  floor_ok;
		mode_t mode;
		logic  len_zero;
		logic  len_full;
		logic  scan_done;
	} dp_stat_t;

endpackage

/* hw/rtl/fdqb_datapath.sv */
// Queue bank datapath: entry memory, length memory, scan pipeline and result registers.
module fdqb_datapath #(
	parameter int FLOORS      = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [fdqb_pkg::MODE_W-1:0]       in_mode,
	input  logic [fdqb_pkg::FLOOR_W-1:0]      in_floor,
	input  logic                              in_going_down,
	input  logic [fdqb_pkg::ID_W-1:0]         in_person_id,
	input  logic [fdqb_pkg::FLOOR_W-1:0]      in_dest_floor,
	input  fdqb_pkg::dp_cmd_t                 cmd,
	output fdqb_pkg::dp_stat_t                stat,
	output logic                              res_status,
	output logic [fdqb_pkg::LEN_OUT_W-1:0]    res_length
);

	`include "floor_direction_queue_bank_defines.svh"

	localparam int FW = $clog2(FLOORS);
	localparam int QW = FW + 1;
	localparam int NQ = 1 << QW;
	localparam int DW = $clog2(QUEUE_DEPTH);
	localparam int AW = QW + DW;
	localparam int NE = 1 << AW;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	// Captured request.
	fdqb_pkg::mode_t                 mode_q;
	logic                            floor_ok_q;
	logic [QW-1:0]                   q_idx_q;
	logic [fdqb_pkg::ID_W-1:0]       id_q;
	logic [fdqb_pkg::FLOOR_W-1:0]    dest_q;
	logic [6:0]                      floor_m1;

	// Length memory with per-queue valid bits.
	logic [LW-1:0]                   len_mem [NQ];
	logic [NQ-1:0]                   len_vld_q;
	logic [LW-1:0]                   len_rd_q;
	logic                            len_vld_rd_q;
	logic [LW-1:0]                   len_cur;
	logic [LW-1:0]                   len_inc;
	logic [LW-1:0]                   len_dec;
	logic                            len_we;
	logic [LW-1:0]                   len_wdata;

	// Entry memory and scan pipeline.
	logic [fdqb_pkg::ENTRY_W-1:0]    ent_mem [NE];
	logic [fdqb_pkg::ENTRY_W-1:0]    ent_rd_s1;
	logic [LW-1:0]                   rd_idx_q;
	logic [LW-1:0]                   rd_idx_s1;
	logic                            rd_vld_s1;
	logic                            found_q;
	logic                            issue;
	logic                            match;
	logic                            scan_wr;
	logic [LW-1:0]                   wr_idx;
	logic                            ent_we;
	logic [AW-1:0]                   ent_waddr;
	logic [fdqb_pkg::ENTRY_W-1:0]    ent_wdata;
	logic [AW-1:0]                   ent_raddr;

	logic                            res_status_q;
	logic [fdqb_pkg::LEN_OUT_W-1:0]  res_length_q;

	assign floor_m1 = 7'(in_floor) - 7'd1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= fdqb_pkg::mode_t'(in_mode);
			floor_ok_q <= (in_floor != '0) && (7'(in_floor) <= 7'(FLOORS));
			q_idx_q    <= {floor_m1[FW-1:0], in_going_down};
			id_q       <= in_person_id;
			dest_q     <= in_dest_floor;
		end
	end

	assign len_cur   = len_vld_rd_q ? len_rd_q : '0;
	assign len_inc   = len_cur + LW'(1);
	assign len_dec   = len_cur - LW'(1);
	assign len_we    = cmd.enq || (cmd.finish && found_q);
	assign len_wdata = cmd.enq ? len_inc : len_dec;

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[q_idx_q] <= len_wdata;
		end
		if (cmd.len_rd) begin
			len_rd_q     <= len_mem[q_idx_q];
			len_vld_rd_q <= len_vld_q[q_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (len_we) begin
			len_vld_q[q_idx_q] <= 1'b1;
		end
	end

	// Scan: read one entry per cycle; once the removed slot is known, each later
	// entry is written back one slot lower.
	assign issue     = cmd.scan_run && (rd_idx_q < len_cur);
	assign match     = ent_rd_s1[fdqb_pkg::ID_W-1:0] == id_q;
	assign scan_wr   = cmd.scan_run && rd_vld_s1 && found_q;
	assign wr_idx    = rd_idx_s1 - LW'(1);
	assign ent_raddr = {q_idx_q, rd_idx_q[DW-1:0]};
	assign ent_we    = cmd.enq || scan_wr;
	assign ent_waddr = cmd.enq ? {q_idx_q, len_cur[DW-1:0]} : {q_idx_q, wr_idx[DW-1:0]};
	assign ent_wdata = cmd.enq ? {dest_q, id_q} : ent_rd_s1;

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		if (issue) begin
			ent_rd_s1 <= ent_mem[ent_raddr];
			rd_idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else if (cmd.scan_init) begin
			// A dequeue removes the head, so it starts already found at slot zero.
			rd_idx_q  <= (mode_q == fdqb_pkg::MODE_DEQ) ? LW'(1) : '0;
			found_q   <= (mode_q == fdqb_pkg::MODE_DEQ);
			rd_vld_s1 <= 1'b0;
		end else if (cmd.scan_run) begin
			if (issue) begin
				rd_idx_q <= rd_idx_q + LW'(1);
			end
			rd_vld_s1 <= issue;
			if (rd_vld_s1 && !found_q && match) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			res_status_q <= 1'b0;
			res_length_q <= fdqb_pkg::LEN_OUT_W'(len_inc);
		end else if (cmd.finish) begin
			res_status_q <= !found_q;
			res_length_q <= found_q ? fdqb_pkg::LEN_OUT_W'(len_dec)
			                        : fdqb_pkg::LEN_OUT_W'(len_cur);
		end else begin
			case (cmd.res_op)
				fdqb_pkg::RES_BAD: begin
					res_status_q <= 1'b1;
					res_length_q <= '0;
				end
				fdqb_pkg::RES_OK_CUR: begin
					res_status_q <= 1'b0;
					res_length_q <= fdqb_pkg::LEN_OUT_W'(len_cur);
				end
				fdqb_pkg::RES_ERR_CUR: begin
					res_status_q <= 1'b1;
					res_length_q <= fdqb_pkg::LEN_OUT_W'(len_cur);
				end
				default: begin
				end
			endcase
		end
	end

	assign res_status = res_status_q;
	assign res_length = res_length_q;

	assign stat.floor_ok  = floor_ok_q;
	assign stat.mode      = mode_q;
	assign stat.len_zero  = (len_cur == '0);
	assign stat.len_full  = (len_cur >= LW'(QUEUE_DEPTH));
	assign stat.scan_done = (rd_idx_q >= len_cur) && !rd_vld_s1;

	`FDQB_ASSERT_NOW(a_scan_wr_slot, clk, arst_n, scan_wr, (rd_idx_s1 != '0) && (rd_idx_s1 < len_cur), "shifted entry written outside the queue")
	`FDQB_ASSERT_NEXT(a_len_bound, clk, arst_n, cmd.len_rd, len_cur <= LW'(QUEUE_DEPTH), "queue length above capacity")
	`FDQB_ASSERT_NOW(a_scan_idx, clk, arst_n, cmd.scan_run, rd_idx_q <= len_cur, "scan index past queue length")

endmodule

/* hw/rtl/fdqb_ctrl.sv */
// Queue bank controller: sequences one request through length read, dispatch, scan where needed, and result hand-off.
module fdqb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_free,
	input  fdqb_pkg::dp_stat_t  stat,
	output logic                ready,
	output logic                push,
	output fdqb_pkg::dp_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN,
		ST_DISP,
		ST_SCAN,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd  = '0;
		push = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid && ready_q;
			end
			ST_LEN: begin
				cmd.len_rd = 1'b1;
			end
			ST_DISP: begin
				if (!stat.floor_ok) begin
					cmd.res_op = fdqb_pkg::RES_BAD;
				end else begin
					case (stat.mode)
						fdqb_pkg::MODE_CNT: begin
							cmd.res_op = fdqb_pkg::RES_OK_CUR;
						end
						fdqb_pkg::MODE_ENQ: begin
							if (stat.len_full) begin
								cmd.res_op = fdqb_pkg::RES_ERR_CUR;
							end else begin
								cmd.enq = 1'b1;
							end
						end
						fdqb_pkg::MODE_DEQ: begin
							if (stat.len_zero) begin
								cmd.res_op = fdqb_pkg::RES_BAD;
							end else begin
								cmd.scan_init = 1'b1;
							end
						end
						fdqb_pkg::MODE_DEL: begin
							cmd.scan_init = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
			end
			ST_DONE: begin
				push = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= ST_LEN;
						ready_q <= 1'b0;
					end
				end
				ST_LEN: begin
					state_q <= ST_DISP;
				end
				ST_DISP: begin
					state_q <= cmd.scan_init ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					if (stat.scan_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign ready = ready_q;

endmodule

/* hw/rtl/floor_direction_queue_bank.sv */
// A count, an enqueue or any request that fails before a scan goes through the length
// read, dispatch and done states; a dequeue or delete also passes the scan and finish
// states; its scan reads one entry per cycle and grows with the queue's length.
// Requests are handled one at a time: the next is taken once the result is registered.
// Reset clears every queue length at once through per-queue valid bits; there is no
// clearing pass, and the entry memory is left as it is.
module floor_direction_queue_bank #(
	parameter int FLOORS      = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	// floor[4:0], going_down[5], person_id[21:6], dest_floor[26:22], zero fill [31:27]
	input  logic [31:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	// length[4:0], zero fill [7:5]
	output logic [7:0]  m_tdata,
	// status[0]
	output logic [0:0]  m_tuser
);

	// Fields of the incoming request, unpacked from the stream payload.
	logic [fdqb_pkg::MODE_W-1:0]       req_mode;
	logic [fdqb_pkg::FLOOR_W-1:0]      req_floor;
	logic                              req_going_down;
	logic [fdqb_pkg::ID_W-1:0]         req_person_id;
	logic [fdqb_pkg::FLOOR_W-1:0]      req_dest_floor;

	fdqb_pkg::dp_cmd_t                 cmd;
	fdqb_pkg::dp_stat_t                stat;
	logic                              res_status;
	logic [fdqb_pkg::LEN_OUT_W-1:0]    res_length;
	logic                              push;
	logic                              out_free;

	// Output register: it holds a finished result while the next request is
	// already accepted and worked on.
	logic                              m_tvalid_q;
	logic [fdqb_pkg::LEN_OUT_W-1:0]    m_length_q;
	logic                              m_status_q;

	assign req_mode       = s_tuser;
	assign req_floor      = s_tdata[4:0];
	assign req_going_down = s_tdata[5];
	assign req_person_id  = s_tdata[21:6];
	assign req_dest_floor = s_tdata[26:22];

	// The result slot is free when empty or when its result leaves in this cycle.
	assign out_free = !m_tvalid_q || m_tready;

	fdqb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.stat     (stat),
		.ready    (s_tready),
		.push     (push),
		.cmd      (cmd)
	);

	fdqb_datapath #(
		.FLOORS      (FLOORS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_mode       (req_mode),
		.in_floor      (req_floor),
		.in_going_down (req_going_down),
		.in_person_id  (req_person_id),
		.in_dest_floor (req_dest_floor),
		.cmd           (cmd),
		.stat          (stat),
		.res_status    (res_status),
		.res_length    (res_length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_length_q <= res_length;
			m_status_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_length_q};
	assign m_tuser  = m_status_q;

endmodule

/* bench/tb.sv */
// Self-checking testbench for the floor and direction queue bank.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Sizes of the bank under test; the instance below uses the same values.
	localparam int FLOORS      = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int QUEUES      = FLOORS * 2;

	// A generous bound on the whole run. The slowest correct run holds about 550
	// requests, each with a scan that grows with its queue's length, a sender gap
	// and a receiver stall, plus one long hold-off.
	localparam int unsigned CYCLE_LIMIT = 400_000;

	// The longest request is a delete through a full queue.
	localparam int SETTLE_CYCLES = 40;

	// Number of mismatches that are printed in full before they are only counted.
	localparam int unsigned REPORT_LIMIT = 10;

	// One request as the bench sees it, field by field.
	typedef struct {
		fdqb_pkg::mode_t mode;
		logic [4:0]      floor;
		logic            down;
		logic [15:0]     id;
		logic [4:0]      dest;
	} queue_req_t;

	// One predicted result, with the request that caused it for the error report.
	typedef struct {
		logic         status;
		logic [4:0]   length;
		queue_req_t   req;
	} queue_result_t;

	// The receiver switches between these ways of applying backpressure.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC
	} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;

	// The bench's own image of the bank: every slot and every queue length.
	logic [fdqb_pkg::ENTRY_W-1:0] slot_mem [QUEUES][QUEUE_DEPTH];
	int                           queue_len [QUEUES];

	// Results that are owed by the block, oldest first.
	queue_result_t owed_results [$];

	int unsigned error_count = 0;

	// Sender burst bookkeeping.
	int burst_left = 0;

	// Receiver state. A test asks for a long hold-off through long_stall_req; the
	// receiver picks it up and counts it down on its own.
	int        long_stall_req = 0;
	int        stall_left     = 0;
	int        style_left     = 0;
	rx_style_t rx_style       = RX_ALWAYS;
	logic [1:0] rx_beat       = 2'd0;

	floor_direction_queue_bank #(
		.FLOORS      (FLOORS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns period clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Queue index for a floor and direction; only valid for floors 1..FLOORS.
	function automatic int queue_index(input logic [4:0] floor, input logic down);
		return (int'(floor) - 1) * 2 + int'(down);
	endfunction

	function automatic bit floor_in_range(input logic [4:0] floor);
		return floor >= 5'd1 && int'(floor) <= FLOORS;
	endfunction

	// Applies one request to the bench's image of the bank and returns the result
	// the block must produce for it.
	function automatic queue_result_t apply_request(input queue_req_t r);
		queue_result_t res;
		int q;
		int len;
		int hit;
		res.req    = r;
		res.status = 1'b1;
		res.length = 5'd0;
		// A floor outside the bank touches nothing and fails with length zero.
		if (!floor_in_range(r.floor))
			return res;
		q   = queue_index(r.floor, r.down);
		len = queue_len[q];
		case (r.mode)
			fdqb_pkg::MODE_ENQ: begin
				// A full queue refuses the entry and reports its length.
				if (len < QUEUE_DEPTH) begin
					slot_mem[q][len] = {r.dest, r.id};
					len++;
					res.status = 1'b0;
				end
			end
			fdqb_pkg::MODE_DEQ: begin
				if (len > 0) begin
					for (int i = 0; i + 1 < len; i++)
						slot_mem[q][i] = slot_mem[q][i + 1];
					len--;
					res.status = 1'b0;
				end
			end
			fdqb_pkg::MODE_DEL: begin
				// Only the first matching entry goes; the rest close up in order.
				hit = -1;
				for (int i = 0; i < len; i++) begin
					if (hit < 0 && slot_mem[q][i][fdqb_pkg::ID_W-1:0] == r.id)
						hit = i;
				end
				if (hit >= 0) begin
					for (int i = hit; i + 1 < len; i++)
						slot_mem[q][i] = slot_mem[q][i + 1];
					len--;
					res.status = 1'b0;
				end
			end
			default: begin
				// A count never fails.
				res.status = 1'b0;
			end
		endcase
		queue_len[q] = len;
		res.length   = 5'(len);
		return res;
	endfunction

	// Offers one request at the falling edge and holds it until the block takes it.
	// Returns at the rising edge of acceptance, with valid still high, so that a
	// following request can go out back to back.
	task automatic send_request(input queue_req_t r);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= r.mode;
		s_tdata  <= {5'b0, r.dest, r.id, r.down, r.floor};
		do
			@(posedge clk);
		while (!s_tready);
		owed_results.push_back(apply_request(r));
	endtask

	// Takes the sender off the bus for a hold-off set by n (n at least one).
	task automatic hold_off(input int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// The sender works in bursts; between bursts it sometimes idles for a while.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0)
				hold_off(gap);
		end
	endtask

	task automatic issue(input fdqb_pkg::mode_t mode, input logic [4:0] floor,
			input logic down, input logic [15:0] id, input logic [4:0] dest);
		queue_req_t r;
		r.mode  = mode;
		r.floor = floor;
		r.down  = down;
		r.id    = id;
		r.dest  = dest;
		send_request(r);
		pace();
	endtask

	// Drops valid and waits until every owed result has come back.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Random id of a live entry of queue q, which must not be empty.
	function automatic logic [15:0] live_id(input int q);
		return slot_mem[q][$urandom_range(0, queue_len[q] - 1)][fdqb_pkg::ID_W-1:0];
	endfunction

	// Builds one random request. Most requests go to a few busy queues so that
	// they grow deep; enq_pct sets how often an entry is added. Deletes mostly
	// name an id that is present, and some enqueues reuse a tiny id pool so that
	// duplicates show up for the first-match rule.
	function automatic queue_req_t make_random_request(input int enq_pct);
		queue_req_t r;
		int pick;
		int q;
		r.down = 1'($urandom_range(0, 1));
		r.id   = 16'($urandom);
		r.dest = 5'($urandom_range(0, 31));
		pick = $urandom_range(0, 99);
		if (pick < 7)
			r.floor = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(FLOORS + 1, 31));
		else if (pick < 70)
			r.floor = 5'($urandom_range(1, 3));
		else
			r.floor = 5'($urandom_range(1, FLOORS));
		pick = $urandom_range(0, 99);
		if (pick < enq_pct)
			r.mode = fdqb_pkg::MODE_ENQ;
		else if (pick < enq_pct + (100 - enq_pct) / 4)
			r.mode = fdqb_pkg::MODE_DEQ;
		else if (pick < 90)
			r.mode = fdqb_pkg::MODE_DEL;
		else
			r.mode = fdqb_pkg::MODE_CNT;
		if (r.mode == fdqb_pkg::MODE_ENQ && $urandom_range(0, 9) == 0)
			r.id = 16'($urandom_range(0, 3));
		if (r.mode == fdqb_pkg::MODE_DEL && floor_in_range(r.floor)) begin
			q = queue_index(r.floor, r.down);
			if (queue_len[q] > 0 && $urandom_range(0, 3) != 0)
				r.id = live_id(q);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// Result checker: every result taken from the block is matched against the
	// oldest owed result, field by field.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d length=%0d",
					m_tuser[0], m_tdata[4:0]));
			end else begin
				want = owed_results.pop_front();
				if (m_tuser[0] !== want.status || m_tdata[4:0] !== want.length)
					report_mismatch($sformatf(
						"%s floor=%0d down=%0d id=%h: expected status=%0d length=%0d, got status=%0d length=%0d",
						want.req.mode.name(), want.req.floor, want.req.down, want.req.id,
						want.status, want.length, m_tuser[0], m_tdata[4:0]));
			end
		end
	end

	// Receiver: changes its backpressure style now and then, and honors a long
	// hold-off when a test asks for one.
	always @(negedge clk) begin
		if (long_stall_req != 0) begin
			stall_left     = long_stall_req;
			long_stall_req = 0;
		end
		if (style_left == 0) begin
			rx_style   = rx_style_t'($urandom_range(0, 2));
			style_left = $urandom_range(50, 300);
		end else begin
			style_left--;
		end
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_style)
				RX_ALWAYS: begin
					m_tready <= 1'b1;
				end
				RX_RANDOM: begin
					m_tready <= ($urandom_range(0, 99) < 60);
				end
				default: begin
					rx_beat = rx_beat + 2'd1;
					m_tready <= (rx_beat != 2'd3);
				end
			endcase
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Edge cases: empty queues, floors outside the bank for every operation, the
	// extreme ids and destinations, delete at the head, in the middle and with no
	// match, and a delete among duplicate ids.
	task automatic test_directed_cases();
		issue(fdqb_pkg::MODE_CNT, 5'd1, 1'b0, 16'h0000, 5'd1);
		issue(fdqb_pkg::MODE_DEQ, 5'd1, 1'b0, 16'h0000, 5'd1);
		issue(fdqb_pkg::MODE_DEL, 5'd1, 1'b0, 16'h0000, 5'd1);
		issue(fdqb_pkg::MODE_ENQ, 5'd0, 1'b0, 16'h1111, 5'd3);
		issue(fdqb_pkg::MODE_DEQ, 5'd17, 1'b1, 16'h2222, 5'd3);
		issue(fdqb_pkg::MODE_DEL, 5'd31, 1'b1, 16'hFFFF, 5'd31);
		issue(fdqb_pkg::MODE_CNT, 5'd0, 1'b1, 16'h0000, 5'd0);
		issue(fdqb_pkg::MODE_ENQ, 5'd1, 1'b0, 16'h0000, 5'd0);
		issue(fdqb_pkg::MODE_ENQ, 5'd1, 1'b0, 16'hFFFF, 5'd31);
		issue(fdqb_pkg::MODE_ENQ, 5'd1, 1'b0, 16'h1234, 5'd16);
		issue(fdqb_pkg::MODE_ENQ, 5'd16, 1'b1, 16'hA5A5, 5'd1);
		issue(fdqb_pkg::MODE_DEL, 5'd1, 1'b0, 16'h5555, 5'd0);
		issue(fdqb_pkg::MODE_DEL, 5'd1, 1'b0, 16'hFFFF, 5'd0);
		issue(fdqb_pkg::MODE_DEL, 5'd1, 1'b0, 16'h0000, 5'd0);
		issue(fdqb_pkg::MODE_DEQ, 5'd1, 1'b0, 16'h0000, 5'd0);
		issue(fdqb_pkg::MODE_DEQ, 5'd16, 1'b1, 16'h0000, 5'd0);
		issue(fdqb_pkg::MODE_ENQ, 5'd2, 1'b1, 16'h0007, 5'd4);
		issue(fdqb_pkg::MODE_ENQ, 5'd2, 1'b1, 16'h0008, 5'd5);
		issue(fdqb_pkg::MODE_ENQ, 5'd2, 1'b1, 16'h0007, 5'd6);
		issue(fdqb_pkg::MODE_DEL, 5'd2, 1'b1, 16'h0007, 5'd0);
		issue(fdqb_pkg::MODE_CNT, 5'd2, 1'b1, 16'h0000, 5'd0);
		issue(fdqb_pkg::MODE_DEQ, 5'd2, 1'b1, 16'h0000, 5'd0);
	endtask

	// The sender stops until every result has come home, then resumes.
	task automatic test_sender_pause();
		wait_drained();
		issue(fdqb_pkg::MODE_CNT, 5'd2, 1'b1, 16'h0000, 5'd0);
	endtask

	// One queue is filled to capacity, pushed past it, then emptied through
	// deletes and dequeues, with one dequeue too many.
	task automatic test_queue_full();
		logic [4:0] floor;
		logic       down;
		int         q;
		floor = 5'($urandom_range(4, FLOORS));
		down  = 1'($urandom_range(0, 1));
		q     = queue_index(floor, down);
		while (queue_len[q] < QUEUE_DEPTH)
			issue(fdqb_pkg::MODE_ENQ, floor, down, 16'($urandom),
				5'($urandom_range(0, 31)));
		issue(fdqb_pkg::MODE_ENQ, floor, down, 16'($urandom), 5'($urandom_range(0, 31)));
		issue(fdqb_pkg::MODE_ENQ, floor, down, 16'hFFFF, 5'd31);
		issue(fdqb_pkg::MODE_CNT, floor, down, 16'h0000, 5'd0);
		issue(fdqb_pkg::MODE_DEL, floor, down,
			slot_mem[q][QUEUE_DEPTH - 1][fdqb_pkg::ID_W-1:0], 5'd0);
		issue(fdqb_pkg::MODE_DEL, floor, down,
			slot_mem[q][QUEUE_DEPTH / 2][fdqb_pkg::ID_W-1:0], 5'd0);
		while (queue_len[q] > 0)
			issue(fdqb_pkg::MODE_DEQ, floor, down, 16'h0000, 5'd0);
		issue(fdqb_pkg::MODE_DEQ, floor, down, 16'h0000, 5'd0);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// requests back to back, so the block has to stall its input.
	task automatic test_backpressure();
		queue_req_t r;
		long_stall_req = 300;
		for (int i = 0; i < 12; i++) begin
			r = make_random_request(50);
			send_request(r);
		end
		wait_drained();
	endtask

	// Random traffic in phases that alternately grow and shrink the busy queues.
	task automatic test_random_traffic(input int count);
		int enq_pct;
		for (int i = 0; i < count; i++) begin
			enq_pct = ((i / 60) % 2 == 0) ? 65 : 25;
			send_request(make_random_request(enq_pct));
			pace();
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = fdqb_pkg::MODE_CNT;
		m_tready = 1'b0;
		for (int q = 0; q < QUEUES; q++)
			queue_len[q] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_sender_pause();
		test_queue_full();
		test_backpressure();
		test_random_traffic(480);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (owed_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
